// ===== design/mbe_pkg.sv =====
// Package for the Mandelbrot escape-time core: fixed-point constants,
// register indexes, sequencer states and the saturation helper.
// No dependencies; every other design file uses it by scoped names.
package mbe_pkg;

  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned IMAGE_SIZE = 4096;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ProdW   = 2 * WordW;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned CountW  = LimitW + 1;
  localparam int unsigned ThreshW = 31;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WordW-1:0] IdxMax = WordW'(IMAGE_SIZE - 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOriginX   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegOriginY   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegStepX     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegStepY     = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegIterLimit = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegThreshold = CfgIdxW'(5);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_CX,
    S_MUL_CY,
    S_MUL_XY,
    S_UPDATE,
    S_MUL_XX,
    S_MUL_YY,
    S_CHECK
  } mbe_state_e;

  // Clamp a wide signed value to the signed word range.
  function automatic logic signed [WordW-1:0] sat_word(input logic signed [ProdW:0] v);
    logic signed [ProdW:0] hi;
    logic signed [ProdW:0] lo;
    hi = (ProdW+1)'(signed'({1'b0, {(WordW-1){1'b1}}}));
    lo = -hi - (ProdW+1)'(1);
    if (v > hi) begin
      return {1'b0, {(WordW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(WordW-1){1'b0}}};
    end else begin
      return v[WordW-1:0];
    end
  endfunction

endpackage

// ===== design/mbe_if.sv =====
// Handshake channels of the Mandelbrot escape-time core: the pixel
// input channel and the iteration-count result channel.
// Depends on mbe_pkg for field widths.
interface mbe_pix_if;
  logic                     valid;
  logic                     ready;
  logic [mbe_pkg::IdxW-1:0] column;
  logic [mbe_pkg::IdxW-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface mbe_cnt_if;
  logic                       valid;
  logic                       ready;
  logic [mbe_pkg::CountW-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

// ===== design/mandelbrot_escape_time_core.sv =====
// Top level of the Mandelbrot escape-time core: configuration registers,
// a small sequencer and one shared signed 32x32 multiplier.
// Depends on mbe_pkg and the channel interfaces in mbe_if.sv.
//
// Usage: pix_i carries one pixel (column, row) per transfer; res_o returns
// one iteration_count per pixel, in order. The configuration port writes
// one register per cycle while cfg_we_i is high; use it only while the core
// is idle; the core does not enforce it. Unknown register indexes are ignored.
//
// Datapath: every multiplication goes through the single multiplier, whose
// result is registered. Forming the point c uses the column and row
// products, and each pass of z = z*z + c runs three products, an update
// and the magnitude check. A pixel takes at most the limit plus one
// passes. The result register is loaded in the same cycle as the core
// returns to idle. One pixel is handled at a time: pix_i.ready is high
// only while the core is idle.
//
// The result sits in an output register, so the core goes back to idle
// and takes a new pixel while res_o is stalled; if the next result is
// finished before the old one is taken, the core holds it until then.
// Reset returns the configuration registers to their defaults and leaves the
// core idle with no result pending; datapath registers are not reset.
module mandelbrot_escape_time_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mbe_pkg::WordW-1:0]   cfg_data_i,
  mbe_pix_if.sink                     pix_i,
  mbe_cnt_if.source                   res_o
);

  localparam int unsigned W  = mbe_pkg::WordW;
  localparam int unsigned PW = mbe_pkg::ProdW;

  // Configuration registers.
  logic signed [W-1:0]                origin_x_q, origin_y_q, step_x_q, step_y_q;
  logic [mbe_pkg::LimitW-1:0]         limit_q;
  logic [mbe_pkg::ThreshW-1:0]        thresh_q;

  // Working registers.
  mbe_pkg::mbe_state_e                state_q, state_d;
  logic [mbe_pkg::IdxW-1:0]           col_q, row_q;
  logic signed [W-1:0]                cx_q, cy_q, zx_q, zy_q;
  logic signed [PW-1:0]               sx_q, sy_q, prod_q;
  logic [mbe_pkg::LimitW-1:0]         loop_q;
  logic [mbe_pkg::CountW-1:0]         res_q;
  logic                               res_valid_q;

  // Shared multiplier and sequencer outputs.
  logic signed [W-1:0]                op_a, op_b;
  logic signed [PW-1:0]               prod_d;
  logic                               in_ready;
  logic                               finish;

  // Pass arithmetic.
  logic signed [PW-1:0]               sq_diff;
  logic signed [W-1:0]                zx_new, zy_new, c_point;
  logic [PW-1:0]                      mag;
  logic                               escaped;
  logic                               last_pass;
  logic                               out_free;
  logic [mbe_pkg::CountW-1:0]         count_d;

  logic pix_xfer;
  assign pix_xfer = pix_i.valid && in_ready;
  assign out_free = !res_valid_q || res_o.ready;

  assign prod_d = op_a * op_b;

  // Point coordinate: origin plus the registered index product, saturated.
  always_comb begin
    if (state_q == mbe_pkg::S_MUL_CY) begin
      c_point = mbe_pkg::sat_word((PW+1)'(origin_x_q) + (PW+1)'(prod_q));
    end else begin
      c_point = mbe_pkg::sat_word((PW+1)'(origin_y_q) + (PW+1)'(prod_q));
    end
  end

  // New z from the previous squares and the cross product in prod_q.
  // The cross product is doubled by shifting one place less.
  assign sq_diff = sx_q - sy_q;
  assign zx_new  = mbe_pkg::sat_word((PW+1)'(sq_diff >>> mbe_pkg::FRAC_BITS)
                                     + (PW+1)'(cx_q));
  assign zy_new  = mbe_pkg::sat_word((PW+1)'(prod_q >>> (mbe_pkg::FRAC_BITS - 1))
                                     + (PW+1)'(cy_q));

  // Squared magnitude: sx_q holds the new zx squared, prod_q the new zy squared.
  assign mag       = (PW'(unsigned'(sx_q)) >> mbe_pkg::FRAC_BITS)
                   + (PW'(unsigned'(prod_q)) >> mbe_pkg::FRAC_BITS);
  assign escaped   = mag > PW'(thresh_q);
  assign last_pass = escaped || (loop_q == limit_q);
  assign count_d   = escaped ? {1'b0, loop_q}
                             : {1'b0, loop_q} + mbe_pkg::CountW'(1);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbe_pkg::S_IDLE:   if (pix_i.valid) state_d = mbe_pkg::S_MUL_CX;
      mbe_pkg::S_MUL_CX: state_d = mbe_pkg::S_MUL_CY;
      mbe_pkg::S_MUL_CY: state_d = mbe_pkg::S_MUL_XY;
      mbe_pkg::S_MUL_XY: state_d = mbe_pkg::S_UPDATE;
      mbe_pkg::S_UPDATE: state_d = mbe_pkg::S_MUL_XX;
      mbe_pkg::S_MUL_XX: state_d = mbe_pkg::S_MUL_YY;
      mbe_pkg::S_MUL_YY: state_d = mbe_pkg::S_CHECK;
      mbe_pkg::S_CHECK: begin
        if (!last_pass) begin
          state_d = mbe_pkg::S_MUL_XY;
        end else if (out_free) begin
          state_d = mbe_pkg::S_IDLE;
        end
      end
      default: state_d = mbe_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operand selection and handshake controls.
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state_q)
      mbe_pkg::S_IDLE:   in_ready = 1'b1;
      mbe_pkg::S_MUL_CX: begin
        op_a = signed'(W'(col_q));
        op_b = step_x_q;
      end
      mbe_pkg::S_MUL_CY: begin
        op_a = signed'(W'(row_q));
        op_b = step_y_q;
      end
      mbe_pkg::S_MUL_XY: begin
        op_a = zx_q;
        op_b = zy_q;
      end
      mbe_pkg::S_UPDATE: ;
      mbe_pkg::S_MUL_XX: begin
        op_a = zx_q;
        op_b = zx_q;
      end
      mbe_pkg::S_MUL_YY: begin
        op_a = zy_q;
        op_b = zy_q;
      end
      mbe_pkg::S_CHECK: begin
        // Keep zy squared in prod_q so the escape test holds while a
        // finished result waits for the output register.
        op_a   = zy_q;
        op_b   = zy_q;
        finish = last_pass && out_free;
      end
      default: ;
    endcase
  end

  assign pix_i.ready           = in_ready;
  assign res_o.valid           = res_valid_q;
  assign res_o.iteration_count = res_q;

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::S_IDLE;
      loop_q      <= '0;
      res_valid_q <= 1'b0;
      origin_x_q  <= -32'sd536870912;
      origin_y_q  <= -32'sd402653184;
      step_x_q    <= 32'sd196608;
      step_y_q    <= 32'sd196608;
      limit_q     <= 16'd255;
      thresh_q    <= 31'd1073741824;
    end else begin
      state_q <= state_d;
      if (pix_xfer) begin
        loop_q <= '0;
      end else if (state_q == mbe_pkg::S_CHECK && !last_pass) begin
        loop_q <= loop_q + mbe_pkg::LimitW'(1);
      end
      if (finish) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          mbe_pkg::RegOriginX:   origin_x_q <= cfg_data_i;
          mbe_pkg::RegOriginY:   origin_y_q <= cfg_data_i;
          mbe_pkg::RegStepX:     step_x_q   <= cfg_data_i;
          mbe_pkg::RegStepY:     step_y_q   <= cfg_data_i;
          mbe_pkg::RegIterLimit: limit_q    <= cfg_data_i[mbe_pkg::LimitW-1:0];
          mbe_pkg::RegThreshold: thresh_q   <= cfg_data_i[mbe_pkg::ThreshW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers; these carry no reset.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (pix_xfer) begin
      // Indexes past the image are pinned to its last column or row.
      col_q <= ({{(W-mbe_pkg::IdxW){1'b0}}, pix_i.column} > mbe_pkg::IdxMax)
             ? mbe_pkg::IdxMax[mbe_pkg::IdxW-1:0] : pix_i.column;
      row_q <= ({{(W-mbe_pkg::IdxW){1'b0}}, pix_i.row} > mbe_pkg::IdxMax)
             ? mbe_pkg::IdxMax[mbe_pkg::IdxW-1:0] : pix_i.row;
      zx_q  <= '0;
      zy_q  <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
    end
    case (state_q)
      mbe_pkg::S_MUL_CY: cx_q <= c_point;
      mbe_pkg::S_MUL_XY: begin
        // Only the first pass has a fresh cy product waiting; later passes
        // find a square in prod_q and must leave cy alone.
        if (loop_q == '0 && sx_q == '0 && sy_q == '0 && zx_q == '0 && zy_q == '0) begin
          cy_q <= c_point;
        end
      end
      mbe_pkg::S_UPDATE: begin
        zx_q <= zx_new;
        zy_q <= zy_new;
      end
      mbe_pkg::S_MUL_YY: sx_q <= prod_q;
      mbe_pkg::S_CHECK:  sy_q <= prod_q;
      default: ;
    endcase
    if (finish) begin
      res_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A result never exceeds one more than the limit it was computed under.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.iteration_count <= {1'b0, limit_q} + mbe_pkg::CountW'(1)))
    else $error("iteration count above limit plus one");

  // The pass counter stays within the limit while a pixel is in work.
  a_loop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mbe_pkg::S_IDLE) |-> (loop_q <= limit_q))
    else $error("pass counter ran past the limit");

  // Once a pixel is taken, no second pixel is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel taken while busy");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(res_o.iteration_count))
    else $error("pending result overwritten");
`endif

endmodule

// ===== sim/mandelbrot_escape_time_core_tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time core.
// Depends on mbe_pkg, the channel interfaces in mbe_if.sv and the core itself.
`timescale 1ns / 100ps

module mandelbrot_escape_time_core_tb;
  import mbe_pkg::*;

  // Register indexes past the last real register; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] RegUnusedA = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegUnusedB = CfgIdxW'(7);

  // Q4.28 constants used by the directed tests.
  localparam logic signed [WordW-1:0] FixZero     = 32'sh0000_0000;
  localparam logic signed [WordW-1:0] FixOne      = 32'sh1000_0000;
  localparam logic signed [WordW-1:0] FixTwoHalf  = 32'sh2800_0000;
  localparam logic signed [WordW-1:0] FixMax      = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] FixMin      = 32'sh8000_0000;
  localparam logic [ThreshW-1:0]      ThreshZero  = 31'h0000_0000;
  localparam logic [ThreshW-1:0]      ThreshFour  = 31'h4000_0000;
  localparam logic [ThreshW-1:0]      ThreshMax   = 31'h7FFF_FFFF;

  // The slowest correct run has every random pixel orbiting for 256 passes,
  // plus the 65536-pass orbit; CycleLimit leaves ample room on top of that
  // for handshake gaps and stalls.
  localparam longint unsigned CycleLimit = 3_000_000;

  // One complete set of view registers, held at the widths of the core.
  typedef struct packed {
    logic signed [WordW-1:0] origin_x;
    logic signed [WordW-1:0] origin_y;
    logic signed [WordW-1:0] step_x;
    logic signed [WordW-1:0] step_y;
    logic [LimitW-1:0]       limit;
    logic [ThreshW-1:0]      threshold;
  } view_t;

  // A pixel that has been transferred in, together with the count it must produce.
  typedef struct packed {
    logic [IdxW-1:0]   column;
    logic [IdxW-1:0]   row;
    logic [CountW-1:0] count;
  } pixel_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [WordW-1:0]    cfg_data_i;

  mbe_pix_if pix ();
  mbe_cnt_if res ();

  mandelbrot_escape_time_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix),
    .res_o       (res)
  );

  // The testbench's own copy of the view registers, starting from the reset values
  // (-2.0, -1.5, 3/4096, 3/4096, a limit of 255 and a threshold of 4.0).
  view_t view = '{origin_x: -32'sd536870912, origin_y: -32'sd402653184,
                  step_x: 32'sd196608, step_y: 32'sd196608,
                  limit: 16'd255, threshold: ThreshFour};

  // Counts still owed by the core, oldest first.
  pixel_result_t pending_counts[$];

  int unsigned     pixel_gap_pct    = 0;
  int unsigned     result_stall_pct = 0;
  int unsigned     failure_count    = 0;
  int unsigned     pixels_sent      = 0;
  int unsigned     counts_checked   = 0;
  int unsigned     settings_loaded  = 0;
  int unsigned     largest_count    = 0;
  longint unsigned cycle_count      = 0;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: a hung core or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles with %0d counts outstanding.",
             cycle_count, pending_counts.size());
    $display("TEST FAILED");
    $finish;
  end

  // Clamp a wide value to the signed 32-bit range, as the core does for c and z.
  function automatic longint clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
    return v;
  endfunction

  // Work out the escape count of one pixel under the current view. The
  // products are exact in 64 bits, and an arithmetic right shift of a signed
  // value is the floor division that the fixed-point rules call for.
  function automatic logic [CountW-1:0] escape_count(input logic [IdxW-1:0] column,
                                                     input logic [IdxW-1:0] row);
    longint      cx;
    longint      cy;
    longint      zx;
    longint      zy;
    longint      re;
    longint      im;
    longint      mag;
    int unsigned pass;
    cx = clamp32(longint'(view.origin_x) + longint'(column) * longint'(view.step_x));
    cy = clamp32(longint'(view.origin_y) + longint'(row) * longint'(view.step_y));
    zx = 0;
    zy = 0;
    for (pass = 0; pass <= view.limit; pass++) begin
      re = clamp32(((zx * zx - zy * zy) >>> FRAC_BITS) + cx);
      im = clamp32(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
      zx = re;
      zy = im;
      mag = ((zx * zx) >>> FRAC_BITS) + ((zy * zy) >>> FRAC_BITS);
      if (mag > longint'(view.threshold)) break;
    end
    return CountW'(pass);
  endfunction

  function automatic void note_failure(input string msg);
    failure_count++;
    if (failure_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endfunction

  // Result side: every transfer on the count channel is compared with the
  // oldest outstanding pixel, and ready is stalled at random each cycle.
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_counts.size() == 0) begin
        note_failure($sformatf("count %0d arrived with no pixel outstanding",
                               res.iteration_count));
      end else begin
        want = pending_counts.pop_front();
        counts_checked++;
        if (res.iteration_count !== want.count) begin
          note_failure($sformatf("pixel (%0d,%0d): expected count %0d, got %0d",
                                 want.column, want.row, want.count, res.iteration_count));
        end
        if (want.count > largest_count) largest_count = want.count;
      end
    end
    res.ready <= rst_ni && ($urandom_range(99) >= result_stall_pct);
  end

  // Write one register and keep the local copy in step. The write enable is
  // left high so that back-to-back writes need only one assignment per edge;
  // the caller lowers it after the last one.
  task automatic write_register(input logic [CfgIdxW-1:0] index, input logic [WordW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (index)
      RegOriginX:   view.origin_x  = data;
      RegOriginY:   view.origin_y  = data;
      RegStepX:     view.step_x    = data;
      RegStepY:     view.step_y    = data;
      RegIterLimit: view.limit     = data[LimitW-1:0];
      RegThreshold: view.threshold = data[ThreshW-1:0];
      default: ;
    endcase
  endtask

  // Load a whole view. The unused upper bits of the limit and threshold
  // words carry random junk, which the core must drop.
  task automatic load_settings(input view_t v);
    write_register(RegOriginX, v.origin_x);
    write_register(RegOriginY, v.origin_y);
    write_register(RegStepX, v.step_x);
    write_register(RegStepY, v.step_y);
    write_register(RegIterLimit, {16'($urandom), v.limit});
    write_register(RegThreshold, {1'($urandom), v.threshold});
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // Hold the pixel channel off until every outstanding count has come back,
  // then leave the core a few quiet cycles. Registers are only written after this.
  task automatic drain_pixels();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Offer one pixel, with a random gap in front of it, and wait for the
  // transfer. Valid is left high afterwards so that a following pixel can go
  // straight out; anything that lets time pass first must lower it.
  task automatic send_pixel(input logic [IdxW-1:0] column, input logic [IdxW-1:0] row);
    pixel_result_t item;
    while ($urandom_range(99) < pixel_gap_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid  <= 1'b1;
    pix.column <= column;
    pix.row    <= row;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    item.column = column;
    item.row    = row;
    item.count  = escape_count(column, row);
    pending_counts.push_back(item);
    pixels_sent++;
  endtask

  // Random view: mostly a window over the interesting part of the plane with
  // small steps, so that counts spread out, and now and then pure noise in
  // every register but the limit, which stays at 40 or below.
  function automatic view_t random_view();
    view_t v;
    if ($urandom_range(3) == 0) begin
      v.origin_x  = $urandom;
      v.origin_y  = $urandom;
      v.step_x    = $urandom;
      v.step_y    = $urandom;
      v.threshold = ThreshW'($urandom);
      v.limit     = LimitW'($urandom_range(0, 40));
    end else begin
      v.origin_x  = WordW'(-671088640 + int'($urandom_range(0, 939524096)));
      v.origin_y  = WordW'(-402653184 + int'($urandom_range(0, 805306368)));
      v.step_x    = WordW'(int'($urandom_range(0, 400000)) - 200000);
      v.step_y    = WordW'(int'($urandom_range(0, 400000)) - 200000);
      v.threshold = ($urandom_range(4) == 0) ? ThreshW'($urandom) : ThreshFour;
      v.limit     = ($urandom_range(7) == 0) ? LimitW'(255) : LimitW'($urandom_range(0, 48));
    end
    return v;
  endfunction

  // The reset view spans -2.0 .. 1.0 by -1.5 .. 1.5. Besides the corners it
  // holds c = 0 and c = -1, which never escape, and c = -2, where |z|^2 sits
  // exactly on the 4.0 threshold and so must never count as an escape.
  task automatic check_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2730, 12'd2048);
    send_pixel(12'd1365, 12'd2048);
    send_pixel(12'd0, 12'd2048);
  endtask

  // Origins and steps at both ends of the signed range push c outside it,
  // so the point itself has to saturate.
  task automatic check_point_saturation();
    drain_pixels();
    load_settings('{origin_x: FixMax, origin_y: FixMax, step_x: FixMax, step_y: FixMax,
                    limit: 16'd3, threshold: ThreshFour});
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    drain_pixels();
    load_settings('{origin_x: FixMin, origin_y: FixMin, step_x: FixMin, step_y: FixMin,
                    limit: 16'd3, threshold: ThreshFour});
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd4095);
  endtask

  // With the threshold near 8.0, c = 2.5 survives the first pass and then
  // drives the real part past the word range, which must still escape.
  task automatic check_component_overflow();
    drain_pixels();
    load_settings('{origin_x: FixTwoHalf, origin_y: FixZero, step_x: FixZero, step_y: FixZero,
                    limit: 16'd10, threshold: ThreshMax});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain_pixels();
    load_settings('{origin_x: FixZero, origin_y: FixTwoHalf, step_x: FixZero, step_y: FixZero,
                    limit: 16'd10, threshold: ThreshMax});
    send_pixel(12'd0, 12'd0);
  endtask

  // A zero limit with a zero threshold, writes to the unused register
  // indexes, and the largest limit with points that escape early.
  task automatic check_register_extremes();
    drain_pixels();
    load_settings('{origin_x: FixZero, origin_y: FixZero, step_x: 32'sd1, step_y: FixZero,
                    limit: 16'd0, threshold: ThreshZero});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain_pixels();
    write_register(RegUnusedA, 32'hFFFF_FFFF);
    write_register(RegUnusedB, $urandom);
    cfg_we_i <= 1'b0;
    send_pixel(12'd4095, 12'd0);
    drain_pixels();
    load_settings('{origin_x: FixOne, origin_y: FixZero, step_x: FixOne, step_y: FixZero,
                    limit: 16'hFFFF, threshold: ThreshFour});
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
  endtask

  // c = 0 at the largest limit never escapes, so the count needs all 17 bits.
  task automatic check_long_orbit();
    drain_pixels();
    load_settings('{origin_x: FixZero, origin_y: FixZero, step_x: FixZero, step_y: FixZero,
                    limit: 16'hFFFF, threshold: ThreshFour});
    send_pixel(IdxW'($urandom), IdxW'($urandom));
  endtask

  // Random pixels over a run of random views. Every so often the sender also
  // holds off until the core has returned every count, without a new view.
  task automatic run_random_views(input int unsigned total, input int unsigned gap_pct,
                                  input int unsigned stall_pct);
    int unsigned sent_here;
    int unsigned until_change;
    pixel_gap_pct    = gap_pct;
    result_stall_pct = stall_pct;
    sent_here        = 0;
    until_change     = 0;
    while (sent_here < total) begin
      if (until_change == 0) begin
        drain_pixels();
        load_settings(random_view());
        until_change = $urandom_range(12, 30);
      end else if ($urandom_range(49) == 0) begin
        drain_pixels();
      end
      send_pixel(IdxW'($urandom), IdxW'($urandom));
      sent_here++;
      until_change--;
    end
  endtask

  initial begin
    // Every input is known from time zero, while reset is held low.
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    pix.valid   = 1'b0;
    pix.column  = '0;
    pix.row     = '0;
    res.ready   = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks run with the first idle mix: a sender that rarely pauses
    // and a receiver that stalls more often than not.
    pixel_gap_pct    = 8;
    result_stall_pct = 57;
    check_reset_view();
    check_point_saturation();
    check_component_overflow();
    check_register_extremes();
    check_long_orbit();

    run_random_views(177, 8, 57);
    run_random_views(177, 57, 8);
    run_random_views(177, 0, 0);

    // Wait for the last counts, then long enough for a full orbit at the
    // default limit so that any stray transfer is caught.
    drain_pixels();
    repeat (1300) @(posedge clk_i);

    $display("Checked %0d escape counts from %0d pixels under %0d register views.",
             counts_checked, pixels_sent, settings_loaded);
    $display("Largest count %0d; %0d failures over %0d cycles.",
             largest_count, failure_count, cycle_count);
    if (failure_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbe_pkg.sv
design/mbe_if.sv
design/mandelbrot_escape_time_core.sv
sim/mandelbrot_escape_time_core_tb.sv
